@@ rtl/arm_ik_pkg.sv @@
// Shared types, constants and arctangent table for the two-link arm solver.
package arm_ik_pkg;

	// Field and datapath widths
	localparam int COORD_W = 24;
	localparam int LINK_W = 23;
	localparam int NUM_W = 49;
	localparam int MAG_W = 48;
	localparam int DEN_W = 47;
	localparam int CQ_W = 31;
	localparam int ANG_W = 34;
	localparam int CORD_W = 44;
	localparam int PROD_W = 48;
	localparam int STEP_Q_W = 16;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Pipeline depths
	localparam int DIV_STEPS = 30;
	localparam int SQRT_STEPS = 31;
	localparam int NORM_STEPS = 6;
	localparam int ATAN_EXTRA = NORM_STEPS + 2;
	localparam int QUEUE_DEPTH = 4;

	// Angle and step constants (angles in Q30 radians)
	localparam logic [ANG_W-1:0] PI_Q30 = 34'd3373259426;
	localparam logic [ANG_W-1:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic [14:0] STEPS_PER_HALF_TURN = 15'd25600;
	localparam logic [STEP_Q_W-1:0] SHOULDER_LIMIT = 16'd51200;
	localparam logic [STEP_Q_W-1:0] ELBOW_LIMIT = 16'd25600;
	localparam logic [LINK_W-1:0] LINK_RESET = 23'd256;

	// Reciprocal of pi in steps: floor(25600 * 2^49 / pi_q30); the estimate
	// it gives is the exact count or one below
	localparam int RECIP_SHIFT = 49;
	localparam logic [31:0] STEP_RECIP =
		32'((64'(STEPS_PER_HALF_TURN) << RECIP_SHIFT) / 64'(PI_Q30));

	// Register index codes (address bit 2)
	localparam logic REG_FIRST_LINK = 1'b0;
	localparam logic REG_SECOND_LINK = 1'b1;

	// Word handed from the front end to the solver
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [LINK_W-1:0] l1;
		logic [LINK_W-1:0] l2;
		logic neg;
		logic eq;
		logic unreach;
		logic [MAG_W-1:0] mag;
		logic [DEN_W-1:0] den;
	} front_item_t;

	// floor(atan(2^-i) * 2^30)
	function automatic logic [31:0] atan_const(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd843314856;
			1: v = 32'd497837829;
			2: v = 32'd263043836;
			3: v = 32'd133525158;
			4: v = 32'd67021686;
			5: v = 32'd33543515;
			6: v = 32'd16775850;
			7: v = 32'd8388437;
			8: v = 32'd4194282;
			9: v = 32'd2097149;
			10: v = 32'd1048575;
			default: v = (i <= 30) ? ((32'd1 << (30 - i)) - 32'd1) : 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/arm_ik_front.sv @@
// Front end: accepts targets, forms the cosine numerator and denominator, classifies reach.
module arm_ik_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [arm_ik_pkg::COORD_W-1:0] x,
	input logic signed [arm_ik_pkg::COORD_W-1:0] y,
	input logic [arm_ik_pkg::LINK_W-1:0] l1,
	input logic [arm_ik_pkg::LINK_W-1:0] l2,
	output logic out_valid,
	input logic out_ready,
	output arm_ik_pkg::front_item_t out_item
);
	import arm_ik_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [47:0] xx_p, yy_p;
	logic [45:0] l11_p, l22_p, l12_p;

	logic signed [COORD_W-1:0] x_s1, y_s1, x_s2, y_s2;
	logic [LINK_W-1:0] l1_s1, l2_s1, l1_s2, l2_s2;
	logic [46:0] xx_s1, yy_s1;
	logic [45:0] l11_s1, l22_s1, l12_s1;
	logic signed [NUM_W-1:0] num_n, num_s2;
	logic [DEN_W-1:0] den_s2;
	logic [NUM_W-1:0] mag_n;
	front_item_t item_s3;

	// Advance all stages when the last one is empty or drained
	assign en = !v_s3 || out_ready;
	assign in_ready = en;

	assign xx_p = x * x;
	assign yy_p = y * y;
	assign l11_p = l1 * l1;
	assign l22_p = l2 * l2;
	assign l12_p = l1 * l2;

	assign num_n = $signed({2'b00, xx_s1}) + $signed({2'b00, yy_s1})
		- $signed({3'b000, l11_s1}) - $signed({3'b000, l22_s1});
	assign mag_n = num_s2[NUM_W-1] ? NUM_W'(-num_s2) : NUM_W'(num_s2);

	// Hold stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Squares and link product, then numerator, then magnitude and reach
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			y_s1 <= y;
			l1_s1 <= l1;
			l2_s1 <= l2;
			xx_s1 <= xx_p[46:0];
			yy_s1 <= yy_p[46:0];
			l11_s1 <= l11_p;
			l22_s1 <= l22_p;
			l12_s1 <= l12_p;

			x_s2 <= x_s1;
			y_s2 <= y_s1;
			l1_s2 <= l1_s1;
			l2_s2 <= l2_s1;
			num_s2 <= num_n;
			den_s2 <= {l12_s1, 1'b0};

			item_s3.x <= x_s2;
			item_s3.y <= y_s2;
			item_s3.l1 <= l1_s2;
			item_s3.l2 <= l2_s2;
			item_s3.neg <= num_s2[NUM_W-1];
			item_s3.mag <= mag_n[MAG_W-1:0];
			item_s3.den <= den_s2;
			item_s3.eq <= (mag_n[MAG_W-1:0] == {1'b0, den_s2});
			item_s3.unreach <= (den_s2 == '0) || (mag_n[MAG_W-1:0] > {1'b0, den_s2});
		end
	end

	assign out_valid = v_s3;
	assign out_item = item_s3;

endmodule

@@ rtl/arm_ik_fifo.sv @@
// Short queue between the front end and the solver.
module arm_ik_fifo (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input arm_ik_pkg::front_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output arm_ik_pkg::front_item_t out_item
);
	import arm_ik_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	front_item_t mem_q [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] count_q;
	logic push, pop;

	assign in_ready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_item = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

endmodule

@@ rtl/arm_ik_atan2.sv @@
// Pipelined vectoring CORDIC: quadrant-correct atan2 in Q30 radians.
module arm_ik_atan2 #(
	parameter int CORDIC_ITERATIONS = 24
) (
	input logic clk,
	input logic en,
	input logic signed [63:0] y,
	input logic signed [63:0] x,
	output logic signed [arm_ik_pkg::ANG_W-1:0] angle
);
	import arm_ik_pkg::*;

	localparam int N = CORDIC_ITERATIONS;
	localparam int FL_LAST = NORM_STEPS + N;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zz;
		logic yz;
		logic xz;
	} atan_flags_t;

	atan_flags_t fl [0:FL_LAST];
	logic [63:0] nx [0:NORM_STEPS];
	logic [63:0] ny [0:NORM_STEPS];
	logic signed [CORD_W-1:0] cx [0:N];
	logic signed [CORD_W-1:0] cy [0:N];
	logic signed [ANG_W-1:0] z [0:N];

	logic signed [ANG_W-1:0] half_s, pi_s, zc, mag;

	// Take magnitudes and note the special cases
	always_ff @(posedge clk) begin
		if (en) begin
			nx[0] <= x[63] ? 64'(-x) : 64'(x);
			ny[0] <= y[63] ? 64'(-y) : 64'(y);
			fl[0].xneg <= x[63];
			fl[0].yneg <= y[63];
			fl[0].zz <= (x == '0) && (y == '0);
			fl[0].yz <= (y == '0);
			fl[0].xz <= (x == '0);
		end
	end

	// Normalize so that the larger magnitude fills the top bit
	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int S = 32 >> j;
		logic [63:0] both;
		assign both = nx[j] | ny[j];
		always_ff @(posedge clk) begin
			if (en) begin
				if (both[63 -: S] == '0) begin
					nx[j+1] <= nx[j] << S;
					ny[j+1] <= ny[j] << S;
				end else begin
					nx[j+1] <= nx[j];
					ny[j+1] <= ny[j];
				end
				fl[j+1] <= fl[j];
			end
		end
	end

	assign cx[0] = $signed({3'b000, nx[NORM_STEPS][63:23]});
	assign cy[0] = $signed({3'b000, ny[NORM_STEPS][63:23]});
	assign z[0] = '0;

	// Rotate toward the x axis, one micro-rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [CORD_W-1:0] dx, dy;
		localparam logic [31:0] ATN = atan_const(i);
		assign dx = cy[i] >>> i;
		assign dy = cx[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy[i][CORD_W-1]) begin
					cx[i+1] <= cx[i] + dx;
					cy[i+1] <= cy[i] - dy;
					z[i+1] <= z[i] + $signed({2'b00, ATN});
				end else begin
					cx[i+1] <= cx[i] - dx;
					cy[i+1] <= cy[i] + dy;
					z[i+1] <= z[i] - $signed({2'b00, ATN});
				end
				fl[NORM_STEPS+i+1] <= fl[NORM_STEPS+i];
			end
		end
	end

	// Clamp to the first quadrant and map to the target quadrant
	assign half_s = $signed(HALF_PI_Q30);
	assign pi_s = $signed(PI_Q30);

	always_comb begin
		zc = z[N];
		if (zc < 0) zc = '0;
		if (zc > half_s) zc = half_s;
		if (fl[FL_LAST].zz || fl[FL_LAST].yz) mag = '0;
		else if (fl[FL_LAST].xz) mag = half_s;
		else mag = zc;
		if (fl[FL_LAST].xneg) mag = pi_s - mag;
		if (fl[FL_LAST].yneg) mag = -mag;
	end

	always_ff @(posedge clk) begin
		if (en) angle <= mag;
	end

endmodule

@@ rtl/arm_ik_back.sv @@
// Solver: cosine division, sine root, three atan2 units and step conversion.
module arm_ik_back #(
	parameter int CORDIC_ITERATIONS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input arm_ik_pkg::front_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output logic shoulder_dir,
	output logic [15:0] shoulder_steps,
	output logic elbow_dir,
	output logic [14:0] elbow_steps,
	output logic unreachable
);
	import arm_ik_pkg::*;

	localparam int LAT = CORDIC_ITERATIONS + ATAN_EXTRA;

	logic en;
	logic out_valid_q;

	// Whole pipeline moves when the output register is free or drained
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// ---------------- cosine magnitude: restoring division ----------------
	logic dv [0:DIV_STEPS];
	logic [MAG_W-1:0] dr [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dq [0:DIV_STEPS];
	front_item_t dctx [0:DIV_STEPS];

	assign dv[0] = in_valid;
	assign dr[0] = in_item.mag;
	assign dq[0] = '0;
	assign dctx[0] = in_item;

	for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
		logic [MAG_W:0] sh, dd;
		logic take;
		assign sh = {dr[gi], 1'b0};
		assign dd = {2'b00, dctx[gi].den};
		assign take = (sh >= dd);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[gi+1] <= 1'b0;
			else if (en) dv[gi+1] <= dv[gi];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dr[gi+1] <= take ? MAG_W'(sh - dd) : sh[MAG_W-1:0];
				dq[gi+1] <= {dq[gi][DIV_STEPS-2:0], take};
				dctx[gi+1] <= dctx[gi];
			end
		end
	end

	// ---------------- signed cosine and its square ----------------
	logic [CQ_W-1:0] cm_n;
	logic signed [31:0] cm_sv, c_n;
	logic [61:0] csq_p;
	logic v_c1, v_c2;
	logic signed [31:0] c_c1, c_c2;
	logic [60:0] csq_c1, n_c2;
	front_item_t ctx_c1, ctx_c2;

	assign cm_n = dctx[DIV_STEPS].eq ? {1'b1, 30'd0} : {1'b0, dq[DIV_STEPS]};
	assign cm_sv = {1'b0, cm_n};
	assign c_n = dctx[DIV_STEPS].neg ? -cm_sv : cm_sv;
	assign csq_p = cm_n * cm_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
		end else if (en) begin
			v_c1 <= dv[DIV_STEPS];
			v_c2 <= v_c1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_c1 <= c_n;
			csq_c1 <= csq_p[60:0];
			ctx_c1 <= dctx[DIV_STEPS];
			c_c2 <= c_c1;
			n_c2 <= {1'b1, 60'd0} - csq_c1;
			ctx_c2 <= ctx_c1;
		end
	end

	// ---------------- sine: digit-by-digit square root ----------------
	logic sv [0:SQRT_STEPS];
	logic [61:0] sn [0:SQRT_STEPS];
	logic [32:0] srem [0:SQRT_STEPS];
	logic [30:0] sroot [0:SQRT_STEPS];
	logic signed [31:0] sc [0:SQRT_STEPS];
	front_item_t sctx [0:SQRT_STEPS];

	assign sv[0] = v_c2;
	assign sn[0] = {1'b0, n_c2};
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign sc[0] = c_c2;
	assign sctx[0] = ctx_c2;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [34:0] trial, tst;
		logic take;
		assign trial = {srem[k], sn[k][61:60]};
		assign tst = {2'b00, sroot[k], 2'b01};
		assign take = (trial >= tst);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[k+1] <= 1'b0;
			else if (en) sv[k+1] <= sv[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				srem[k+1] <= take ? 33'(trial - tst) : trial[32:0];
				sroot[k+1] <= {sroot[k][29:0], take};
				sn[k+1] <= {sn[k][59:0], 2'b00};
				sc[k+1] <= sc[k];
				sctx[k+1] <= sctx[k];
			end
		end
	end

	// ---------------- second-link vector ----------------
	logic signed [23:0] l2s;
	logic signed [55:0] l1_term, prod_term, k1_n;
	logic [53:0] k2_n;
	logic v_k, u_k;
	logic signed [55:0] k1_k;
	logic [53:0] k2_k;
	logic signed [31:0] c_k;
	logic [30:0] s_k;
	logic signed [COORD_W-1:0] x_k, y_k;

	assign l2s = {1'b0, sctx[SQRT_STEPS].l2};
	assign l1_term = {3'b000, sctx[SQRT_STEPS].l1, 30'd0};
	assign prod_term = l2s * sc[SQRT_STEPS];
	assign k1_n = l1_term + prod_term;
	assign k2_n = sctx[SQRT_STEPS].l2 * sroot[SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_k <= 1'b0;
		else if (en) v_k <= sv[SQRT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k1_k <= k1_n;
			k2_k <= k2_n;
			c_k <= sc[SQRT_STEPS];
			s_k <= sroot[SQRT_STEPS];
			x_k <= sctx[SQRT_STEPS].x;
			y_k <= sctx[SQRT_STEPS].y;
			u_k <= sctx[SQRT_STEPS].unreach;
		end
	end

	// ---------------- three angle units side by side ----------------
	logic signed [63:0] beta_y, beta_x, tgt_y, tgt_x, lnk_y, lnk_x;
	logic signed [ANG_W-1:0] th_beta, th_tgt, th_lnk;

	assign beta_y = {33'd0, s_k};
	assign beta_x = 64'(c_k);
	assign tgt_y = 64'(y_k);
	assign tgt_x = 64'(x_k);
	assign lnk_y = {10'd0, k2_k};
	assign lnk_x = 64'(k1_k);

	arm_ik_atan2 #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_beta (
		.clk(clk), .en(en), .y(beta_y), .x(beta_x), .angle(th_beta)
	);
	arm_ik_atan2 #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_target (
		.clk(clk), .en(en), .y(tgt_y), .x(tgt_x), .angle(th_tgt)
	);
	arm_ik_atan2 #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_link (
		.clk(clk), .en(en), .y(lnk_y), .x(lnk_x), .angle(th_lnk)
	);

	// Carry valid and reach flag alongside the angle units
	logic tv [0:LAT];
	logic tu [0:LAT];
	assign tv[0] = v_k;
	assign tu[0] = u_k;

	for (genvar t = 0; t < LAT; t++) begin : g_tdly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tv[t+1] <= 1'b0;
			else if (en) tv[t+1] <= tv[t];
		end
		always_ff @(posedge clk) begin
			if (en) tu[t+1] <= tu[t];
		end
	end

	// ---------------- joint angles, scaled magnitudes and estimates ----------------
	logic v_a, u_a, v_b, u_b;
	logic signed [ANG_W-1:0] alpha_a, beta_a;
	logic [ANG_W-1:0] alpha_abs, beta_abs;
	logic [PROD_W-1:0] pa_n, pb_n, pa_b, pb_b;
	logic [64:0] ea_p, eb_p;
	logic [STEP_Q_W-1:0] ea_b, eb_b;
	logic na_b, nb_b;

	assign alpha_abs = alpha_a[ANG_W-1] ? ANG_W'(-alpha_a) : ANG_W'(alpha_a);
	assign beta_abs = beta_a[ANG_W-1] ? ANG_W'(-beta_a) : ANG_W'(beta_a);
	assign pa_n = alpha_abs[32:0] * STEPS_PER_HALF_TURN;
	assign pb_n = beta_abs[32:0] * STEPS_PER_HALF_TURN;
	assign ea_p = alpha_abs[32:0] * STEP_RECIP;
	assign eb_p = beta_abs[32:0] * STEP_RECIP;

	// ---------------- step counts: check the estimate against pi ----------------
	logic v_c, u_c, na_c, nb_c;
	logic v_d, u_d, na_d, nb_d;
	logic [PROD_W-1:0] pa_c, pb_c, ba_c, bb_c, ra_n, rb_n;
	logic [STEP_Q_W-1:0] ea_c, eb_c, qa_d, qb_d;

	assign ra_n = pa_c - ba_c;
	assign rb_n = pb_c - bb_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
			v_b <= 1'b0;
			v_c <= 1'b0;
			v_d <= 1'b0;
		end else if (en) begin
			v_a <= tv[LAT];
			v_b <= v_a;
			v_c <= v_b;
			v_d <= v_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_a <= th_tgt - th_lnk;
			beta_a <= th_beta;
			u_a <= tu[LAT];
			pa_b <= pa_n;
			pb_b <= pb_n;
			ea_b <= ea_p[RECIP_SHIFT +: STEP_Q_W];
			eb_b <= eb_p[RECIP_SHIFT +: STEP_Q_W];
			na_b <= alpha_a[ANG_W-1];
			nb_b <= beta_a[ANG_W-1];
			u_b <= u_a;

			// Multiply the estimate back by pi
			pa_c <= pa_b;
			pb_c <= pb_b;
			ba_c <= ea_b * PI_Q30;
			bb_c <= eb_b * PI_Q30;
			ea_c <= ea_b;
			eb_c <= eb_b;
			na_c <= na_b;
			nb_c <= nb_b;
			u_c <= u_b;

			// Bump the estimate when a whole pi is left over
			qa_d <= ea_c + {{(STEP_Q_W-1){1'b0}}, (ra_n >= PROD_W'(PI_Q30))};
			qb_d <= eb_c + {{(STEP_Q_W-1){1'b0}}, (rb_n >= PROD_W'(PI_Q30))};
			na_d <= na_c;
			nb_d <= nb_c;
			u_d <= u_c;
		end
	end

	// ---------------- saturate, sign and register the result ----------------
	logic [STEP_Q_W-1:0] sa, sb;
	logic ua;

	assign ua = u_d;
	assign sa = (qa_d > SHOULDER_LIMIT) ? SHOULDER_LIMIT : qa_d;
	assign sb = (qb_d > ELBOW_LIMIT) ? ELBOW_LIMIT : qb_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unreachable <= ua;
			shoulder_steps <= ua ? '0 : sa;
			elbow_steps <= ua ? '0 : sb[14:0];
			shoulder_dir <= ua || !na_d || (sa == '0);
			elbow_dir <= ua || !nb_d || (sb == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/two_link_arm_inverse_kinematics_top.sv @@
// Top level of the two-link arm inverse kinematics solver.
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+-------------------------------------
//  target    | target_valid / target_ready     | target_x, target_y
//  result    | result_valid / result_ready     | shoulder_dir/_steps, elbow_dir/_steps,
//            |                                 | unreachable
//  config    | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One target is taken per cycle unless a stalled result has filled the queue; the solver is fully pipelined.
// A target passes through the three front stages, the queue, the 30-step cosine divider,
// the 31-step square root, the CORDIC stages with eight more for normalizing and quadrant
// mapping, and the step-scaling registers.
// Reset clears the link lengths to 1.0 and empties every stage and the queue.
// A stalled result freezes the solver; the front end keeps filling the queue until full.
module two_link_arm_inverse_kinematics_top #(
	parameter int CORDIC_ITERATIONS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [arm_ik_pkg::ADDR_W-1:0] paddr,
	input logic [arm_ik_pkg::DATA_W-1:0] pwdata,
	output logic [arm_ik_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input logic target_valid,
	output logic target_ready,
	input logic signed [arm_ik_pkg::COORD_W-1:0] target_x,
	input logic signed [arm_ik_pkg::COORD_W-1:0] target_y,
	output logic result_valid,
	input logic result_ready,
	output logic shoulder_dir,
	output logic [15:0] shoulder_steps,
	output logic elbow_dir,
	output logic [14:0] elbow_steps,
	output logic unreachable
);
	import arm_ik_pkg::*;

	logic [LINK_W-1:0] link1_q, link2_q;
	logic wr_en;
	logic f_valid, f_ready, b_valid, b_ready;
	front_item_t f_item, b_item;

	// Write link lengths
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link1_q <= LINK_RESET;
			link2_q <= LINK_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_FIRST_LINK: link1_q <= pwdata[LINK_W-1:0];
				REG_SECOND_LINK: link2_q <= pwdata[LINK_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			REG_FIRST_LINK: prdata = {{(DATA_W-LINK_W){1'b0}}, link1_q};
			REG_SECOND_LINK: prdata = {{(DATA_W-LINK_W){1'b0}}, link2_q};
			default: prdata = '0;
		endcase
	end

	arm_ik_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(target_valid), .in_ready(target_ready),
		.x(target_x), .y(target_y), .l1(link1_q), .l2(link2_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	arm_ik_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
	);

	arm_ik_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
		.out_valid(result_valid), .out_ready(result_ready),
		.shoulder_dir(shoulder_dir), .shoulder_steps(shoulder_steps),
		.elbow_dir(elbow_dir), .elbow_steps(elbow_steps),
		.unreachable(unreachable)
	);

	// Out-of-reach results carry zero counts and positive directions
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && unreachable |->
			shoulder_steps == '0 && elbow_steps == '0 && shoulder_dir && elbow_dir)
		else $error("unreachable result with nonzero counts");

	// Counts stay within one turn and half a turn
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> shoulder_steps <= SHOULDER_LIMIT && elbow_steps <= 15'd25600)
		else $error("step count out of range");

	// A zero count always reports the positive direction
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (shoulder_steps == '0 || elbow_steps == '0) |->
			(shoulder_steps != '0 || shoulder_dir) && (elbow_steps != '0 || elbow_dir))
		else $error("zero count with negative direction");

endmodule
